### sv/drt_pkg.sv
// ----------------------------------------------------------------------------
// Dirty rectangle tracker package
// Shared coordinate width, action and result codes, and the structs passed
// between the clipping and box-tracking stages.
// ----------------------------------------------------------------------------
package drt_pkg;

    // Coordinates are unsigned 13-bit values, 0 to 8191.
    localparam int COORD_W = 13;
    localparam int IN_W    = 16;

    // Action codes of an input transfer.
    localparam logic [1:0] ACT_MARK_RECT = 2'd0;
    localparam logic [1:0] ACT_MARK_ALL  = 2'd1;
    localparam logic [1:0] ACT_CONSUME   = 2'd2;

    // Result kind codes.
    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_RECT     = 2'd1;
    localparam logic [1:0] KIND_FULL     = 2'd2;
    localparam logic [1:0] KIND_CONSUMED = 2'd3;

    // A rectangle after clipping, right and bottom edges exclusive.
    typedef struct packed {
        logic               hit;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
    } drt_clip_t;

    // One result item.
    typedef struct packed {
        logic [1:0]         kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
    } drt_result_t;

endpackage

### sv/drt_clip.sv
// ----------------------------------------------------------------------------
// Rectangle clipper
// Rejects empty or off-screen rectangles and clips the rest to the screen.
// ----------------------------------------------------------------------------
module drt_clip #(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 768
) (
    input  logic signed [15:0] rect_left,
    input  logic signed [15:0] rect_top,
    input  logic signed [15:0] rect_w,
    input  logic signed [15:0] rect_h,
    output drt_pkg::drt_clip_t clip
);
    import drt_pkg::*;

    localparam logic [COORD_W-1:0] SW_C = COORD_W'(SCREEN_WIDTH);
    localparam logic [COORD_W-1:0] SH_C = COORD_W'(SCREEN_HEIGHT);

    logic signed [IN_W:0] x0_ext;
    logic signed [IN_W:0] y0_ext;
    logic signed [IN_W:0] x1_ext;
    logic signed [IN_W:0] y1_ext;
    logic signed [IN_W:0] sw_ext;
    logic signed [IN_W:0] sh_ext;
    logic                 reject;

    // Edges are widened by one bit so that the far-edge sum cannot overflow.
    always_comb begin
        x0_ext = {rect_left[IN_W-1], rect_left};
        y0_ext = {rect_top[IN_W-1], rect_top};
        x1_ext = x0_ext + {rect_w[IN_W-1], rect_w};
        y1_ext = y0_ext + {rect_h[IN_W-1], rect_h};
        sw_ext = $signed({{(IN_W + 1 - COORD_W){1'b0}}, SW_C});
        sh_ext = $signed({{(IN_W + 1 - COORD_W){1'b0}}, SH_C});
    end

    // A rectangle is dropped when it has no area or misses the screen.
    always_comb begin
        reject = (rect_w <= 16'sd0) || (rect_h <= 16'sd0)
              || (x1_ext <= 17'sd0) || (y1_ext <= 17'sd0)
              || (x0_ext >= sw_ext) || (y0_ext >= sh_ext);
        clip.hit = !reject;
        clip.x0  = x0_ext[IN_W] ? '0 : x0_ext[COORD_W-1:0];
        clip.y0  = y0_ext[IN_W] ? '0 : y0_ext[COORD_W-1:0];
        clip.x1  = (x1_ext > sw_ext) ? SW_C : x1_ext[COORD_W-1:0];
        clip.y1  = (y1_ext > sh_ext) ? SH_C : y1_ext[COORD_W-1:0];
    end

endmodule

### sv/drt_box.sv
// ----------------------------------------------------------------------------
// Damage box tracker
// Holds the pending full-screen flag and the bounding box, applies one action
// per transfer and forms the matching result.
// ----------------------------------------------------------------------------
module drt_box #(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 768
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  fire,
    input  logic [1:0]            action,
    input  drt_pkg::drt_clip_t    clip,
    output drt_pkg::drt_result_t  result
);
    import drt_pkg::*;

    localparam logic [COORD_W-1:0] SW_C = COORD_W'(SCREEN_WIDTH);
    localparam logic [COORD_W-1:0] SH_C = COORD_W'(SCREEN_HEIGHT);

    logic               full_reg,   full_next;
    logic               active_reg, active_next;
    logic [COORD_W-1:0] left_reg,   left_next;
    logic [COORD_W-1:0] top_reg,    top_next;
    logic [COORD_W-1:0] right_reg,  right_next;
    logic [COORD_W-1:0] bottom_reg, bottom_next;
    logic [COORD_W-1:0] cx1;
    logic [COORD_W-1:0] cy1;

    // Box clipped against the screen for a consume.
    always_comb begin
        cx1 = (right_reg > SW_C) ? SW_C : right_reg;
        cy1 = (bottom_reg > SH_C) ? SH_C : bottom_reg;
    end

    // Next state and result for the action in hand.
    always_comb begin
        full_next   = full_reg;
        active_next = active_reg;
        left_next   = left_reg;
        top_next    = top_reg;
        right_next  = right_reg;
        bottom_next = bottom_reg;
        result      = '0;
        unique case (action)
            ACT_MARK_RECT: begin
                if (clip.hit) begin
                    result.kind = KIND_RECT;
                    result.x    = clip.x0;
                    result.y    = clip.y0;
                    result.w    = clip.x1 - clip.x0;
                    result.h    = clip.y1 - clip.y0;
                    if (!full_reg) begin
                        active_next = 1'b1;
                        if (!active_reg) begin
                            left_next   = clip.x0;
                            top_next    = clip.y0;
                            right_next  = clip.x1;
                            bottom_next = clip.y1;
                        end else begin
                            if (clip.x0 < left_reg)   left_next   = clip.x0;
                            if (clip.y0 < top_reg)    top_next    = clip.y0;
                            if (clip.x1 > right_reg)  right_next  = clip.x1;
                            if (clip.y1 > bottom_reg) bottom_next = clip.y1;
                        end
                    end
                end
            end
            ACT_MARK_ALL: begin
                full_next   = 1'b1;
                active_next = 1'b0;
                left_next   = '0;
                top_next    = '0;
                right_next  = SW_C;
                bottom_next = SH_C;
                result.kind = KIND_FULL;
                result.w    = SW_C;
                result.h    = SH_C;
            end
            ACT_CONSUME: begin
                active_next = 1'b0;
                if (full_reg) begin
                    full_next   = 1'b0;
                    result.kind = KIND_CONSUMED;
                    result.w    = SW_C;
                    result.h    = SH_C;
                end else if (active_reg && (cx1 > left_reg) && (cy1 > top_reg)) begin
                    result.kind = KIND_CONSUMED;
                    result.x    = left_reg;
                    result.y    = top_reg;
                    result.w    = cx1 - left_reg;
                    result.h    = cy1 - top_reg;
                end
            end
            default: begin
                result = '0;
            end
        endcase
    end

    // State moves only when an item leaves the input stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg   <= 1'b1;
            active_reg <= 1'b0;
            left_reg   <= '0;
            top_reg    <= '0;
            right_reg  <= SW_C;
            bottom_reg <= SH_C;
        end else if (fire) begin
            full_reg   <= full_next;
            active_reg <= active_next;
            left_reg   <= left_next;
            top_reg    <= top_next;
            right_reg  <= right_next;
            bottom_reg <= bottom_next;
        end
    end

endmodule

### sv/dirty_rect_tracker_core.sv
// ----------------------------------------------------------------------------
// Dirty rectangle tracker core
// Screen damage tracker: marks clipped rectangles or the whole screen and
// hands out the accumulated damage box on a consume.
//
//   Channel | Direction | Handshake         | Payload
//   s_      | in        | s_valid / s_ready | action, rect_left/top/w/h
//   m_      | out       | m_valid / m_ready | kind, out_x/y/width/height
//
// Each transfer is captured in an input register; the clip and box update
// run combinationally on it and land in the result register. One item is
// taken per cycle unless m_ready stalls the output. The damage state updates
// as an item moves into the result register. Reset leaves a full-screen
// repaint pending. A stalled m_ready holds the result and fills the input
// register; s_ready falls only when both are occupied.
// ----------------------------------------------------------------------------
module dirty_rect_tracker_core #(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 768
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_action,
    input  logic signed [15:0] s_rect_left,
    input  logic signed [15:0] s_rect_top,
    input  logic signed [15:0] s_rect_w,
    input  logic signed [15:0] s_rect_h,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_kind,
    output logic [12:0]        m_out_x,
    output logic [12:0]        m_out_y,
    output logic [12:0]        m_out_width,
    output logic [12:0]        m_out_height
);
    import drt_pkg::*;

    logic               in_valid_reg;
    logic [1:0]         action_reg;
    logic signed [15:0] left_reg;
    logic signed [15:0] top_reg;
    logic signed [15:0] w_reg;
    logic signed [15:0] h_reg;
    logic               out_valid_reg;
    drt_result_t        out_reg;
    drt_clip_t          clip;
    drt_result_t        result;
    logic               advance;
    logic               take;

    // Handshake: the input stage moves on whenever the result slot is free or being read out.
    always_comb begin
        advance = in_valid_reg && (!out_valid_reg || m_ready);
        s_ready = !in_valid_reg || advance;
        take    = s_valid && s_ready;
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            action_reg <= s_action;
            left_reg   <= s_rect_left;
            top_reg    <= s_rect_top;
            w_reg      <= s_rect_w;
            h_reg      <= s_rect_h;
        end
    end

    drt_clip #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_clip (
        .rect_left (left_reg),
        .rect_top  (top_reg),
        .rect_w    (w_reg),
        .rect_h    (h_reg),
        .clip      (clip)
    );

    drt_box #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_box (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .action  (action_reg),
        .clip    (clip),
        .result  (result)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_kind       = out_reg.kind;
    assign m_out_x      = out_reg.x;
    assign m_out_y      = out_reg.y;
    assign m_out_width  = out_reg.w;
    assign m_out_height = out_reg.h;

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// Dirty rectangle tracker testbench
// Drives mark, mark-all and consume actions into the tracker core over the
// s_ channel and checks every m_ transfer against a behavioural model of the
// damage state. Both sides idle in random bursts, and the input side pauses
// twice until all outstanding results have drained.
// ----------------------------------------------------------------------------
module tb_top;
    import drt_pkg::*;

    // Behavioural model of the damage state with a queue of pending results.
    class damage_scoreboard;
        int          scr_w;
        int          scr_h;
        bit          full_pending;
        bit          box_active;
        int          box_l;
        int          box_t;
        int          box_r;
        int          box_b;
        drt_result_t damage_q[$];
        int          mismatches;
        int          kind_seen[4];

        function new(int w, int h);
            scr_w = w;
            scr_h = h;
            mismatches = 0;
            foreach (kind_seen[k]) kind_seen[k] = 0;
            full_pending = 1'b1;
            clear_box();
        endfunction

        function void clear_box();
            box_active = 1'b0;
            box_l = 0;
            box_t = 0;
            box_r = scr_w;
            box_b = scr_h;
        endfunction

        function int pending();
            return damage_q.size();
        endfunction

        // Work out the result of one accepted input transfer and queue it.
        function void note_transfer(logic [1:0] act, logic signed [15:0] l,
                                    logic signed [15:0] t, logic signed [15:0] w,
                                    logic signed [15:0] h);
            int          x0;
            int          y0;
            int          x1;
            int          y1;
            drt_result_t r;
            r = '0;
            x0 = int'(l);
            y0 = int'(t);
            case (act)
                ACT_MARK_RECT: begin
                    x1 = x0 + int'(w);
                    y1 = y0 + int'(h);
                    // Rectangles of no area or wholly off screen are dropped.
                    if (w > 0 && h > 0 && x1 > 0 && y1 > 0 &&
                        x0 < scr_w && y0 < scr_h) begin
                        if (x0 < 0) x0 = 0;
                        if (y0 < 0) y0 = 0;
                        if (x1 > scr_w) x1 = scr_w;
                        if (y1 > scr_h) y1 = scr_h;
                        r.kind = KIND_RECT;
                        r.x = x0[12:0];
                        r.y = y0[12:0];
                        r.w = 13'(x1 - x0);
                        r.h = 13'(y1 - y0);
                        // The box only grows when no whole-screen repaint is due.
                        if (!full_pending) begin
                            if (!box_active) begin
                                box_active = 1'b1;
                                box_l = x0;
                                box_t = y0;
                                box_r = x1;
                                box_b = y1;
                            end else begin
                                if (x0 < box_l) box_l = x0;
                                if (y0 < box_t) box_t = y0;
                                if (x1 > box_r) box_r = x1;
                                if (y1 > box_b) box_b = y1;
                            end
                        end
                    end
                end
                ACT_MARK_ALL: begin
                    full_pending = 1'b1;
                    clear_box();
                    r.kind = KIND_FULL;
                    r.w = 13'(scr_w);
                    r.h = 13'(scr_h);
                end
                ACT_CONSUME: begin
                    if (full_pending) begin
                        full_pending = 1'b0;
                        box_active = 1'b0;
                        r.kind = KIND_CONSUMED;
                        r.w = 13'(scr_w);
                        r.h = 13'(scr_h);
                    end else if (box_active) begin
                        box_active = 1'b0;
                        x0 = (box_l < 0) ? 0 : box_l;
                        y0 = (box_t < 0) ? 0 : box_t;
                        x1 = (box_r > scr_w) ? scr_w : box_r;
                        y1 = (box_b > scr_h) ? scr_h : box_b;
                        if (x1 > x0 && y1 > y0) begin
                            r.kind = KIND_CONSUMED;
                            r.x = x0[12:0];
                            r.y = y0[12:0];
                            r.w = 13'(x1 - x0);
                            r.h = 13'(y1 - y0);
                        end
                    end
                end
                default: begin
                    // The unused action code leaves the state alone.
                end
            endcase
            damage_q.push_back(r);
        endfunction

        // Compare one output transfer with the oldest queued result.
        function void check_result(drt_result_t got);
            drt_result_t want;
            if (damage_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result kind=%0d x=%0d y=%0d w=%0d h=%0d",
                             got.kind, got.x, got.y, got.w, got.h);
                return;
            end
            want = damage_q.pop_front();
            kind_seen[want.kind]++;
            if (got.kind !== want.kind || got.x !== want.x || got.y !== want.y ||
                got.w !== want.w || got.h !== want.h) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: result mismatch, expected kind=%0d x=%0d y=%0d w=%0d h=%0d",
                             want.kind, want.x, want.y, want.w, want.h);
                    $display("       actual kind=%0d x=%0d y=%0d w=%0d h=%0d",
                             got.kind, got.x, got.y, got.w, got.h);
                end
            end
        endfunction
    endclass

    localparam int          SCR_W       = 1024;
    localparam int          SCR_H       = 768;
    localparam int          NUM_RANDOM  = 1950;
    localparam int          QUIET_FROM  = 1750;
    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [1:0]  ACT_UNUSED  = 2'd3;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_action;
    logic signed [15:0] s_rect_left;
    logic signed [15:0] s_rect_top;
    logic signed [15:0] s_rect_w;
    logic signed [15:0] s_rect_h;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_kind;
    logic [12:0]        m_out_x;
    logic [12:0]        m_out_y;
    logic [12:0]        m_out_width;
    logic [12:0]        m_out_height;

    damage_scoreboard   sb;
    int                 cycle_count;
    int                 stall_left;
    int                 stall_mode;
    bit                 quiet;

    dirty_rect_tracker_core #(
        .SCREEN_WIDTH (SCR_W),
        .SCREEN_HEIGHT(SCR_H)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_rect_left (s_rect_left),
        .s_rect_top  (s_rect_top),
        .s_rect_w    (s_rect_w),
        .s_rect_h    (s_rect_h),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_out_x     (m_out_x),
        .m_out_y     (m_out_y),
        .m_out_width (m_out_width),
        .m_out_height(m_out_height)
    );

    // Clock with a period of 20.
    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Run-away guard.
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ERROR: timed out after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side back-pressure in random bursts.
    initial stall_left = 0;
    always @(posedge aclk) begin
        if (!aresetn || quiet || stall_mode == 0) begin
            stall_left = 0;
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, (stall_mode == 2) ? 3 : 12) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Every output transfer goes to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result('{m_kind, m_out_x, m_out_y, m_out_width, m_out_height});
    end

    // Offer one item and hold it until the transfer takes place.
    task automatic send_item(logic [1:0] act, logic signed [15:0] l, logic signed [15:0] t,
                             logic signed [15:0] w, logic signed [15:0] h);
        s_valid     <= 1'b1;
        s_action    <= act;
        s_rect_left <= l;
        s_rect_top  <= t;
        s_rect_w    <= w;
        s_rect_h    <= h;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_transfer(act, l, t, w, h);
    endtask

    task automatic idle_input(int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Hold the input side until every queued result has come out.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // One random item, mostly well-formed on-screen marks and consumes.
    task automatic send_random();
        int                 pick;
        logic signed [15:0] l;
        logic signed [15:0] t;
        logic signed [15:0] w;
        logic signed [15:0] h;
        pick = $urandom_range(0, 99);
        l = 16'($urandom());
        t = 16'($urandom());
        w = 16'($urandom());
        h = 16'($urandom());
        if (pick < 55) begin
            l = 16'(int'($urandom_range(0, 1100)) - 40);
            t = 16'(int'($urandom_range(0, 830)) - 40);
            w = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(1, 1200)
                                                : $urandom_range(1, 200));
            h = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(1, 900)
                                                : $urandom_range(1, 200));
            send_item(ACT_MARK_RECT, l, t, w, h);
        end else if (pick < 70) begin
            send_item(ACT_CONSUME, l, t, w, h);
        end else if (pick < 74) begin
            send_item(ACT_MARK_ALL, l, t, w, h);
        end else if (pick < 84) begin
            send_item(ACT_MARK_RECT, l, t, w, h);
        end else if (pick < 90) begin
            // Zero or negative size.
            if ($urandom_range(0, 1)) w = -$signed(16'($urandom_range(0, 32767)));
            else h = -$signed(16'($urandom_range(0, 32767)));
            send_item(ACT_MARK_RECT, l, t, w, h);
        end else if (pick < 94) begin
            send_item(ACT_UNUSED, l, t, w, h);
        end else begin
            // Straddling or just missing a screen edge.
            l = $urandom_range(0, 1) ? -$signed(16'($urandom_range(0, 200)))
                                     : 16'(SCR_W - $urandom_range(0, 200));
            t = $urandom_range(0, 1) ? -$signed(16'($urandom_range(0, 200)))
                                     : 16'(SCR_H - $urandom_range(0, 200));
            w = 16'($urandom_range(1, 400));
            h = 16'($urandom_range(1, 400));
            send_item(ACT_MARK_RECT, l, t, w, h);
        end
    endtask

    // Main sequence.
    initial begin
        sb = new(SCR_W, SCR_H);
        quiet = 1'b0;
        stall_mode = 0;
        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        m_ready     <= 1'b0;
        s_action    <= ACT_MARK_RECT;
        s_rect_left <= '0;
        s_rect_top  <= '0;
        s_rect_w    <= '0;
        s_rect_h    <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: reset state has a whole-screen repaint pending.
        send_item(ACT_MARK_RECT, 16'sd10, 16'sd20, 16'sd30, 16'sd40);
        send_item(ACT_CONSUME, '0, '0, '0, '0);
        send_item(ACT_CONSUME, '0, '0, '0, '0);
        send_item(ACT_MARK_RECT, 16'sd5, 16'sd5, 16'sd0, 16'sd9);
        send_item(ACT_MARK_RECT, 16'sd5, 16'sd5, 16'sd9, 16'sd0);
        send_item(ACT_MARK_RECT, 16'sd0, 16'sd0, -16'sd32768, 16'sd32767);
        send_item(ACT_MARK_RECT, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
        send_item(ACT_MARK_RECT, 16'sd32767, 16'sd0, 16'sd1, 16'sd1);
        send_item(ACT_MARK_RECT, 16'sd0, 16'sd768, 16'sd5, 16'sd5);
        send_item(ACT_MARK_RECT, 16'sd1024, 16'sd0, 16'sd5, 16'sd5);
        send_item(ACT_MARK_RECT, -16'sd1, 16'sd0, 16'sd1, 16'sd1);
        send_item(ACT_MARK_RECT, -16'sd100, -16'sd50, 16'sd32767, 16'sd32767);
        send_item(ACT_CONSUME, '0, '0, '0, '0);
        send_item(ACT_MARK_RECT, 16'sd1023, 16'sd767, 16'sd1, 16'sd1);
        send_item(ACT_MARK_RECT, 16'sd5, 16'sd7, 16'sd3, 16'sd2);
        send_item(ACT_MARK_RECT, -16'sd20, 16'sd700, 16'sd40, 16'sd32767);
        send_item(ACT_CONSUME, '0, '0, '0, '0);
        send_item(ACT_UNUSED, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
        send_item(ACT_MARK_ALL, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        send_item(ACT_MARK_RECT, 16'sd100, 16'sd100, 16'sd50, 16'sd50);
        send_item(ACT_CONSUME, '0, '0, '0, '0);
        send_item(ACT_MARK_RECT, -16'sd32768, -16'sd32768, -16'sd1, -16'sd1);
        send_item(ACT_UNUSED, '0, '0, '0, '0);
        send_item(ACT_CONSUME, '0, '0, '0, '0);
        drain_results();

        // Random part; the idling style changes every hundred items.
        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i % 100 == 0) stall_mode = $urandom_range(0, 2);
            if (i >= QUIET_FROM) quiet = 1'b1;
            if (i == NUM_RANDOM / 2) drain_results();
            if (!quiet && stall_mode != 0 &&
                $urandom_range(0, (stall_mode == 2) ? 3 : 10) == 0)
                idle_input($urandom_range(1, 19));
            send_random();
        end
        s_valid <= 1'b0;

        // Wait for the tail to drain, then for any stray output.
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Covered: %0d clipped marks, %0d whole-screen marks, %0d consumed,",
                 sb.kind_seen[KIND_RECT], sb.kind_seen[KIND_FULL],
                 sb.kind_seen[KIND_CONSUMED]);
        $display("         %0d empty results; mismatches %0d, still outstanding %0d",
                 sb.kind_seen[KIND_NONE], sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
